// File: hw/rtl/irm_pkg.sv
// irm_pkg: types, constants and step decode tables for the i2c register master
// used by irm_step and i2c_register_master; depends on nothing else
package irm_pkg;

	localparam int STEP_W   = 6;
	localparam int BITS_W   = 4;
	localparam int DELAY_W  = 16;

	localparam logic [STEP_W-1:0]  STEP_IDLE   = 6'd0;
	localparam logic [STEP_W-1:0]  FIRST_STEP  = 6'd1;
	localparam logic [STEP_W-1:0]  READ_BASE   = 6'd23;
	localparam logic [STEP_W-1:0]  LAST_STEP   = 6'd53;
	localparam logic [BITS_W-1:0]  BITS_PER_BYTE = 4'd8;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd5;
	localparam logic [DELAY_W-1:0] DELAY_MAX   = 16'hFFFF;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BUS_BUSY = 2'd1,
		STATUS_BUS_ERR  = 2'd2,
		STATUS_NACK     = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		K_IDLE, K_SA, K_SB, K_SC, K_SD, K_TX, K_TH, K_TL, K_AR, K_AH,
		K_RH, K_RL, K_MS, K_MH, K_ML, K_PA, K_PB, K_PC
	} kind_t;

	typedef enum logic [1:0] {
		SRC_DEV, SRC_REG, SRC_DATA, SRC_DEV1
	} src_t;

	typedef struct packed {
		logic       cmd_valid;
		logic       action;
		logic [7:0] device_address;
		logic [7:0] register_address;
		logic [7:0] write_data;
		logic       sda_sample;
	} tick_t;

	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic [1:0] status;
	} res_t;

	// sequencer state carried between ticks
	typedef struct packed {
		logic [STEP_W-1:0]  step;
		logic [BITS_W-1:0]  bit_count;
		logic [7:0]         shift_byte;
		logic [DELAY_W-1:0] delay_count;
		logic [1:0]         held_status;
		logic [7:0]         received_byte;
		logic               scl;
		logic               sda;
	} state_t;

	function automatic kind_t step_kind(input logic [STEP_W-1:0] s);
		kind_t k;
		unique case (s)
			6'd1, 6'd23, 6'd37:                        k = K_SA;
			6'd2, 6'd24, 6'd38:                        k = K_SB;
			6'd3, 6'd25, 6'd39:                        k = K_SC;
			6'd4, 6'd26, 6'd40:                        k = K_SD;
			6'd5, 6'd10, 6'd15, 6'd27, 6'd32, 6'd41:   k = K_TX;
			6'd6, 6'd11, 6'd16, 6'd28, 6'd33, 6'd42:   k = K_TH;
			6'd7, 6'd12, 6'd17, 6'd29, 6'd34, 6'd43:   k = K_TL;
			6'd8, 6'd13, 6'd18, 6'd30, 6'd35, 6'd44:   k = K_AR;
			6'd9, 6'd14, 6'd19, 6'd31, 6'd36, 6'd45:   k = K_AH;
			6'd46:                                     k = K_RH;
			6'd47:                                     k = K_RL;
			6'd48:                                     k = K_MS;
			6'd49:                                     k = K_MH;
			6'd50:                                     k = K_ML;
			6'd20, 6'd51:                              k = K_PA;
			6'd21, 6'd52:                              k = K_PB;
			6'd22, 6'd53:                              k = K_PC;
			default:                                   k = K_IDLE;
		endcase
		return k;
	endfunction

	// byte source of each transmit step
	function automatic src_t step_src(input logic [STEP_W-1:0] s);
		src_t r;
		unique case (s)
			6'd10, 6'd32: r = SRC_REG;
			6'd15:        r = SRC_DATA;
			6'd41:        r = SRC_DEV1;
			default:      r = SRC_DEV;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/irm_step.sv
// irm_step: next-state and line-level logic for one bus tick
// depends on irm_pkg
module irm_step (
	input  irm_pkg::state_t      cur,
	input  irm_pkg::tick_t       tick,
	input  logic [15:0]          delay_ticks,
	output irm_pkg::state_t      nxt,
	output logic                 done
);
	import irm_pkg::*;

	logic              do_enter;
	logic              fresh;
	logic [STEP_W-1:0] tgt;
	logic [DELAY_W-1:0] cnt;
	kind_t             cur_kind;

	assign cur_kind = step_kind(cur.step);
	assign cnt = (cur.delay_count != DELAY_MAX) ? cur.delay_count + 16'd1 : cur.delay_count;

	always_comb begin
		nxt      = cur;
		done     = 1'b0;
		do_enter = 1'b0;
		fresh    = 1'b1;
		tgt      = 6'(cur.step + 6'd1);

		if (cur.step == STEP_IDLE) begin
			if (tick.cmd_valid) begin
				nxt.held_status = STATUS_OK;
				do_enter = 1'b1;
				tgt = tick.action ? READ_BASE : FIRST_STEP;
			end
		end else begin
			nxt.delay_count = cnt;
			if (cnt >= delay_ticks) begin
				do_enter = 1'b1;
				case (cur_kind)
					K_SB: begin
						if (!tick.sda_sample) begin
							if (nxt.held_status == STATUS_OK) nxt.held_status = STATUS_BUS_BUSY;
							// bus busy: skip the rest of the start condition
							tgt = 6'(cur.step + 6'd3);
						end
					end
					K_SD: begin
						if (tick.sda_sample && nxt.held_status == STATUS_OK)
							nxt.held_status = STATUS_BUS_ERR;
					end
					K_TL: begin
						nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
						nxt.bit_count = 4'(cur.bit_count + 4'd1);
						if (nxt.bit_count < BITS_PER_BYTE) begin
							tgt = 6'(cur.step - 6'd2);
							fresh = 1'b0;
						end
					end
					K_AH: begin
						if (tick.sda_sample && nxt.held_status == STATUS_OK)
							nxt.held_status = STATUS_NACK;
						nxt.scl = 1'b0;
					end
					K_RH: begin
						nxt.shift_byte = {cur.shift_byte[6:0], tick.sda_sample};
					end
					K_RL: begin
						nxt.bit_count = 4'(cur.bit_count + 4'd1);
						if (nxt.bit_count < BITS_PER_BYTE) begin
							tgt = 6'(cur.step - 6'd1);
							fresh = 1'b0;
						end
					end
					K_PC: begin
						do_enter = 1'b0;
						if (cur.step == LAST_STEP) nxt.received_byte = cur.shift_byte;
						nxt.step = STEP_IDLE;
						nxt.delay_count = '0;
						done = 1'b1;
					end
					K_IDLE: begin
						do_enter = 1'b0;
						nxt.step = STEP_IDLE;
						nxt.delay_count = '0;
					end
					default: ;
				endcase
			end
		end

		// phase entry drives the new levels
		if (do_enter) begin
			nxt.step = tgt;
			nxt.delay_count = '0;
			case (step_kind(tgt))
				K_SA, K_AR, K_MS, K_PC: nxt.sda = 1'b1;
				K_SC, K_PA:             nxt.sda = 1'b0;
				K_SB, K_TH, K_AH, K_MH, K_PB: nxt.scl = 1'b1;
				K_SD, K_TL, K_RL, K_ML: nxt.scl = 1'b0;
				K_TX: begin
					if (fresh) begin
						case (step_src(tgt))
							SRC_DEV:  nxt.shift_byte = tick.device_address;
							SRC_REG:  nxt.shift_byte = tick.register_address;
							SRC_DATA: nxt.shift_byte = tick.write_data;
							default:  nxt.shift_byte = 8'(tick.device_address + 8'd1);
						endcase
						nxt.bit_count = '0;
					end
					nxt.scl = 1'b0;
					nxt.sda = nxt.shift_byte[7];
				end
				K_RH: begin
					if (fresh) begin
						nxt.shift_byte = '0;
						nxt.bit_count = '0;
					end
					nxt.sda = 1'b1;
					nxt.scl = 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/i2c_register_master.sv
// i2c_register_master: top level, tick input register, sequencer state and result register
// depends on irm_pkg and irm_step
//
// Each accepted tick word is one tick of the bus timebase and yields exactly one result
// word. One tick is taken every clock cycle unless a held result stalls the input; a
// result word passes the input register, then the sequencer update into the result
// register, and a held result can stall it between the two. The rate is set by
// the sequencer state, which is updated once per tick and feeds the
// next tick. A held result stalls the input only while both registers are full.
// delay_ticks sets how many ticks each bus phase lasts; write it only while idle.
module i2c_register_master (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_ready,
	input  irm_pkg::tick_t    tick,
	output logic              res_valid,
	input  logic              res_ready,
	output irm_pkg::res_t     res,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata
);
	import irm_pkg::*;

	tick_t       tick_s1;
	logic        valid_s1;
	res_t        res_s2;
	logic        valid_s2;
	state_t      state_q;
	state_t      state_nxt;
	logic        done;
	logic [15:0] delay_ticks_q;
	logic        advance;

	assign advance    = valid_s1 && (!valid_s2 || res_ready);
	assign tick_ready = !valid_s1 || advance;
	assign res_valid  = valid_s2;
	assign res        = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ticks_q <= DELAY_RESET;
		end else if (cfg_we) begin
			delay_ticks_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_ready && tick_valid) tick_s1 <= tick;
	end

	irm_step u_step (
		.cur         (state_q),
		.tick        (tick_s1),
		.delay_ticks (delay_ticks_q),
		.nxt         (state_nxt),
		.done        (done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.step          <= STEP_IDLE;
			state_q.bit_count     <= '0;
			state_q.shift_byte    <= '0;
			state_q.delay_count   <= '0;
			state_q.held_status   <= STATUS_OK;
			state_q.received_byte <= '0;
			state_q.scl           <= 1'b1;
			state_q.sda           <= 1'b1;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.scl_drive <= state_nxt.scl;
			res_s2.sda_drive <= state_nxt.sda;
			res_s2.busy_res  <= (state_nxt.step != STEP_IDLE);
			res_s2.done_res  <= done;
			res_s2.read_data <= state_nxt.received_byte;
			res_s2.status    <= state_nxt.held_status;
		end
	end

`ifndef ASSERT_OFF
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.step <= LAST_STEP)
		else $error("sequencer step out of range");

	a_bit_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bit_count <= BITS_PER_BYTE)
		else $error("bit count past one byte");

	a_idle_delay: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.step == STEP_IDLE |-> state_q.delay_count == '0)
		else $error("delay counter running while idle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.done_res |-> !res_s2.busy_res)
		else $error("done reported while still busy");

	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("tick processed without a result word");
`endif

endmodule
